### rtl/utf8sh_pkg.sv
package utf8sh_pkg;

    localparam int BYTE_W  = 8;
    localparam int SLOTS   = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // register map, selected by paddr[2]
    localparam logic REG_BOM_SKIP = 1'b0;

    localparam logic [BYTE_W-1:0] BOM_B0 = 8'hEF;
    localparam logic [BYTE_W-1:0] BOM_B1 = 8'hBB;
    localparam logic [BYTE_W-1:0] BOM_B2 = 8'hBF;

    localparam int HASH_SH_LO = 6;
    localparam int HASH_SH_HI = 16;

    typedef enum logic [1:0] {
        LEAD_NONE    = 2'd0,
        LEAD_EF      = 2'd1,
        LEAD_EFBB    = 2'd2,
        LEAD_DECIDED = 2'd3
    } t_lead;

    // one queue entry: up to three bytes to hash in order, plus end of string
    typedef struct packed {
        logic [SLOTS-1:0][BYTE_W-1:0] data;
        logic [1:0]                   nbytes;
        logic                         last;
    } t_entry;

    function automatic logic [BYTE_W-1:0] bom_byte(input t_lead pos);
        logic [BYTE_W-1:0] b;
        case (pos)
            LEAD_NONE: b = BOM_B0;
            LEAD_EF:   b = BOM_B1;
            LEAD_EFBB: b = BOM_B2;
            default:   b = '0;
        endcase
        return b;
    endfunction

endpackage

### rtl/utf8sh_if.sv
interface utf8sh_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface utf8sh_res_if #(
    parameter int COUNT_WIDTH = 32,
    parameter int HASH_WIDTH  = 64
);
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] char_count;
    logic [COUNT_WIDTH-1:0] byte_count;
    logic [HASH_WIDTH-1:0]  hash_result;

    modport source (output valid, output char_count, output byte_count, output hash_result,
                    input ready);
    modport sink   (input valid, input char_count, input byte_count, input hash_result,
                    output ready);
endinterface

### rtl/utf8sh_front.sv
module utf8sh_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    utf8sh_byte_if.sink        i_in,
    input  logic               i_skip_en,
    input  logic               i_push_ready,
    output logic               o_push_valid,
    output utf8sh_pkg::t_entry o_push_entry
);
    import utf8sh_pkg::*;

    t_lead             r_lead;
    t_lead             n_lead;
    logic [BYTE_W-1:0] r_held [SLOTS];

    logic accept;
    logic decided;
    logic match;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid && i_push_ready;
    assign decided    = (r_lead == LEAD_DECIDED);
    assign match      = i_skip_en && !decided && (i_in.byte_value == bom_byte(r_lead));

    // next state
    always_comb begin
        n_lead = r_lead;
        if (accept) begin
            if (i_in.last_byte) begin
                n_lead = LEAD_NONE;
            end else if (decided) begin
                n_lead = LEAD_DECIDED;
            end else if (match) begin
                n_lead = (r_lead == LEAD_EFBB) ? LEAD_DECIDED : t_lead'(r_lead + 2'd1);
            end else begin
                n_lead = LEAD_DECIDED;
            end
        end
    end

    // outputs: held bytes go first, then the current byte
    always_comb begin
        o_push_valid      = 1'b0;
        o_push_entry.last = i_in.last_byte;
        for (int i = 0; i < SLOTS; i++) begin
            o_push_entry.data[i] = (!decided && (i < int'(r_lead))) ? r_held[i]
                                                                      : i_in.byte_value;
        end
        o_push_entry.nbytes = decided ? 2'd1 : 2'(r_lead + 2'd1);
        if (decided) begin
            o_push_valid = accept;
        end else if (match) begin
            if (r_lead == LEAD_EFBB) begin
                // whole mark dropped: only the end of string, if any, goes on
                o_push_valid        = accept && i_in.last_byte;
                o_push_entry.nbytes = 2'd0;
            end else begin
                o_push_valid = accept && i_in.last_byte;
            end
        end else begin
            o_push_valid = accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= LEAD_NONE;
        end else begin
            r_lead <= n_lead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && match && r_lead != LEAD_EFBB) begin
            r_held[r_lead] <= i_in.byte_value;
        end
    end

endmodule

### rtl/utf8sh_queue.sv
module utf8sh_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    input  utf8sh_pkg::t_entry i_push_entry,
    output logic               o_push_ready,
    output logic               o_pop_valid,
    output utf8sh_pkg::t_entry o_pop_entry,
    input  logic               i_pop
);
    import utf8sh_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_PTR_W:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_cnt != (Q_PTR_W+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_entry  = r_mem[r_rd];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_entry;
        end
    end

endmodule

### rtl/utf8sh_back.sv
module utf8sh_back #(
    parameter int HASH_WIDTH  = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    input  utf8sh_pkg::t_entry i_pop_entry,
    output logic               o_pop,
    utf8sh_res_if.source       o_out
);
    import utf8sh_pkg::*;

    logic [HASH_WIDTH-1:0]  r_hash;
    logic [COUNT_WIDTH-1:0] r_chars;
    logic [COUNT_WIDTH-1:0] r_bytes;
    logic [1:0]             r_idx;
    logic                   r_ovalid;
    logic [HASH_WIDTH-1:0]  r_ohash;
    logic [COUNT_WIDTH-1:0] r_ochars;
    logic [COUNT_WIDTH-1:0] r_obytes;

    logic [HASH_WIDTH-1:0]  n_hash;
    logic [COUNT_WIDTH-1:0] n_chars;
    logic [COUNT_WIDTH-1:0] n_bytes;

    logic [BYTE_W-1:0] cur;
    logic              final_byte;
    logic              emit;
    logic              out_free;
    logic              step;
    logic              take;

    assign cur        = i_pop_entry.data[r_idx];
    assign final_byte = (i_pop_entry.nbytes == 2'd0) || (2'(r_idx + 2'd1) == i_pop_entry.nbytes);
    assign out_free   = !r_ovalid || o_out.ready;
    assign emit       = final_byte && i_pop_entry.last;
    assign step       = i_pop_valid && (!emit || out_free);
    assign take       = step && (i_pop_entry.nbytes != 2'd0);
    assign o_pop      = step && final_byte;

    // h * 65599 + c, wrapping
    always_comb begin
        n_hash  = HASH_WIDTH'(cur) + (r_hash << HASH_SH_LO) + (r_hash << HASH_SH_HI) - r_hash;
        n_chars = r_chars;
        n_bytes = r_bytes;
        if ((!cur[7] || cur[6]) && r_chars != '1) begin
            n_chars = r_chars + 1'b1;
        end
        if (r_bytes != '1) begin
            n_bytes = r_bytes + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= '0;
            r_chars  <= '0;
            r_bytes  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_idx <= '0;
            end else if (step) begin
                r_idx <= r_idx + 2'd1;
            end
            if (step && emit) begin
                r_hash  <= '0;
                r_chars <= '0;
                r_bytes <= '0;
            end else if (take) begin
                r_hash  <= n_hash;
                r_chars <= n_chars;
                r_bytes <= n_bytes;
            end
            if (step && emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_ohash  <= take ? n_hash  : r_hash;
            r_ochars <= take ? n_chars : r_chars;
            r_obytes <= take ? n_bytes : r_bytes;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.hash_result = r_ohash;
    assign o_out.char_count  = r_ochars;
    assign o_out.byte_count  = r_obytes;

endmodule

### rtl/utf8_length_and_sdbm_hash.sv
// UTF-8 character count, byte count and SDBM hash of a byte string.
//
// i_in takes one byte per item with last_byte on the final byte of a string.
// o_out gives one item per string: char_count, byte_count and hash_result.
// The APB port holds one register at address 0, bit 0 = bom_skip_enable
// (reset 1); while set, a leading EF BB BF is dropped from the string.
//
// Result path: the entry with the last byte is queued, then the back end hashes
// any replayed held mark bytes and the last byte and loads the output register.
// Throughput: one byte per cycle while the queue has room, once the start of a
// string is decided. The back end hashes one byte per cycle unless a result
// waits for the output register; a mismatch in a partial mark replays up to
// two held bytes there, absorbed by the four-entry queue in front of it.
// A result waits in the output register while o_out.ready is low; bytes of
// the next string keep flowing until its last byte, which then waits, and
// i_in.ready drops when the queue fills.
// Reset (synchronous, active low) clears all counts, the hash, the queue and
// the output valid flag, and sets bom_skip_enable.
module utf8_length_and_sdbm_hash #(
    parameter int HASH_WIDTH  = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    utf8sh_byte_if.sink  i_in,
    utf8sh_res_if.source o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import utf8sh_pkg::*;

    logic   r_bom_skip;
    logic   push_valid;
    logic   push_ready;
    t_entry push_entry;
    logic   pop_valid;
    t_entry pop_entry;
    logic   pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BOM_SKIP) ? {31'b0, r_bom_skip} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bom_skip <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BOM_SKIP) begin
            r_bom_skip <= pwdata[0];
        end
    end

    utf8sh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_skip_en    (r_bom_skip),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry)
    );

    utf8sh_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_entry (push_entry),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_entry  (pop_entry),
        .i_pop        (pop)
    );

    utf8sh_back #(
        .HASH_WIDTH  (HASH_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_entry (pop_entry),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

### rtl/utf8sh_chk.sv
module utf8sh_chk #(
    parameter int HASH_WIDTH  = 64,
    parameter int COUNT_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [COUNT_WIDTH-1:0] i_char_count,
    input logic [COUNT_WIDTH-1:0] i_byte_count,
    input logic [HASH_WIDTH-1:0]  i_hash_result,
    input logic                   i_psel,
    input logic                   i_penable,
    input logic                   i_pwrite,
    input logic [2:0]             i_paddr,
    input logic [31:0]            i_pwdata,
    input logic [31:0]            i_prdata
);

    // every counted character is also a counted byte
    a_chars_le_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_char_count <= i_byte_count))
        else $error("char_count exceeds byte_count");

    // nothing hashed means nothing counted and a zero hash
    a_empty_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_byte_count == '0) |-> (i_char_count == '0 && i_hash_result == '0))
        else $error("empty string gives nonzero result");

    // a register write is read back
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && i_paddr[2] == 1'b0)
            |=> (i_paddr[2] != 1'b0 || i_prdata[0] == $past(i_pwdata[0])))
        else $error("bom_skip_enable readback mismatch");

    // a stalled result stays valid with its hash and byte count held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
            |=> (i_out_valid && $stable(i_hash_result) && $stable(i_byte_count)))
        else $error("result changed while stalled");

endmodule

bind utf8_length_and_sdbm_hash utf8sh_chk #(
    .HASH_WIDTH  (HASH_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
) u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_char_count  (o_out.char_count),
    .i_byte_count  (o_out.byte_count),
    .i_hash_result (o_out.hash_result),
    .i_psel        (psel),
    .i_penable     (penable),
    .i_pwrite      (pwrite),
    .i_paddr       (paddr),
    .i_pwdata      (pwdata),
    .i_prdata      (prdata)
);
